@@ src/wsmv_pkg.sv @@
// ----------------------------------------------------------------------------
// wsmv_pkg
// Types shared by the windowed mean / variance statistics block.
// ----------------------------------------------------------------------------
package wsmv_pkg;

  typedef struct packed {
    logic [31:0] distance;
    logic        has_sample;
    logic        last;
  } wsmv_in_t;

  typedef struct packed {
    logic [31:0] win_mean;
    logic [63:0] win_var;
    logic [31:0] half_mean;
    logic [63:0] half_var;
    logic [31:0] qtr_mean;
    logic [63:0] qtr_var;
    logic [31:0] min_distance;
    logic        overflow;
  } wsmv_out_t;

endpackage

@@ src/window_suffix_mean_variance_min.sv @@
// ----------------------------------------------------------------------------
// window_suffix_mean_variance_min
// Stores distance samples in a memory; on a closing word walks the window,
// accumulating sums for the whole window and its newest half and quarter and
// the window minimum, then divides each sum with a shared bit-serial divider.
//
//   channel | ports                   | handshake
//   in      | start, busy, in_word    | taken when start && !busy
//   out     | done, out_word          | one-cycle strobe, no back-pressure
//
// A sample word is taken without raising busy. A closing word keeps busy high
// through the memory walk, then through a mean and a variance division per
// suffix in the shared divider (both skipped for an empty suffix), and until
// the result is shown.
// Reset clears the count and the drop flag; the memory needs no clearing.
// The receiver cannot stall: the result is shown for one cycle.
// ----------------------------------------------------------------------------
module window_suffix_mean_variance_min
  import wsmv_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  wsmv_in_t  in_word,
  output logic      done,
  output wsmv_out_t out_word
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = 32 + CW;
  localparam int QW = 64 + CW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_SETUP = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [31:0]   mem [WINDOW_MAX];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [CW-1:0] rd_idx;

  logic [SW-1:0] s1 [3];
  logic [QW-1:0] s2 [3];
  logic [31:0]   mn;
  logic [63:0]   sq;
  logic          sq_vld;
  logic [CW-1:0] sq_idx;
  logic [CW-1:0] h_len, q_len;

  // divider job: suffix k, phase (0 mean, 1 variance)
  logic [1:0]    job_k;
  logic          job_v;
  logic [1:0]    mstep;
  logic [127:0]  mul_acc;
  logic [127:0]  dnum;
  logic [63:0]   dden;
  logic [63:0]   drem;
  logic [63:0]   dquo;
  logic [7:0]    dcnt;
  logic [CW-1:0] jlen;
  logic [63:0]   res_m [3];
  logic [63:0]   res_v [3];
  logic [64:0]   rem_sh;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign h_len  = count >> 1;
  assign q_len  = count >> 2;

  always_comb begin
    case (job_k)
      2'd0:    jlen = count;
      2'd1:    jlen = h_len;
      default: jlen = q_len;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && in_word.has_sample && (count < CW'(WINDOW_MAX))) begin
      mem[count[AW-1:0]] <= in_word.distance;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_en   = (state == S_READ) && (idx < count);
  assign rd_addr = idx[AW-1:0];
  assign rem_sh  = {drem, dnum[127]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      done    <= 1'b0;
      rd_pend <= 1'b0;
      sq_vld  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_word.has_sample) begin
              if (count < CW'(WINDOW_MAX)) begin
                count <= count + 1'b1;
              end else begin
                dropped <= 1'b1;
              end
            end
            if (in_word.last) begin
              state <= S_READ;
              idx   <= '0;
              mn    <= '1;
              for (int k = 0; k < 3; k++) begin
                s1[k] <= '0;
                s2[k] <= '0;
              end
            end
          end
        end
        S_READ: begin
          // stage 1: memory read; stage 2: square, sum and minimum; stage 3: sum of squares
          rd_pend <= rd_en;
          rd_idx  <= idx;
          if (rd_en) begin
            idx <= idx + 1'b1;
          end
          sq_vld <= rd_pend;
          sq_idx <= rd_idx;
          if (rd_pend) begin
            sq <= 64'(rd_data) * 64'(rd_data);
            if (rd_data < mn) begin
              mn <= rd_data;
            end
            s1[0] <= s1[0] + SW'(rd_data);
            if (rd_idx >= count - h_len) begin
              s1[1] <= s1[1] + SW'(rd_data);
            end
            if (rd_idx >= count - q_len) begin
              s1[2] <= s1[2] + SW'(rd_data);
            end
          end
          if (sq_vld) begin
            s2[0] <= s2[0] + QW'(sq);
            if (sq_idx >= count - h_len) begin
              s2[1] <= s2[1] + QW'(sq);
            end
            if (sq_idx >= count - q_len) begin
              s2[2] <= s2[2] + QW'(sq);
            end
          end
          if (!rd_en && !rd_pend && !sq_vld) begin
            job_k <= 2'd0;
            job_v <= 1'b0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          mstep <= '0;
          dquo  <= '0;
          if (!job_v) begin
            dnum  <= 128'(s1[job_k]) << 64;
            dden  <= 64'(jlen);
            drem  <= '0;
            dcnt  <= 8'd64;
            state <= S_DIV;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // n*S2, then S1*S1 from its low and high parts, then n*S2 - S1*S1; one step per cycle
          case (mstep)
            2'd0: begin
              mul_acc <= 128'(s2[job_k]) * 128'(jlen);
              mstep   <= 2'd1;
            end
            2'd1: begin
              dnum  <= 128'(s1[job_k][31:0]) * 128'(s1[job_k][31:0]);
              mstep <= 2'd2;
            end
            2'd2: begin
              dnum  <= dnum + ((128'(s1[job_k][31:0]) * 128'(s1[job_k][SW-1:32])) << 33)
                            + ((128'(s1[job_k][SW-1:32]) * 128'(s1[job_k][SW-1:32])) << 64);
              mstep <= 2'd3;
            end
            default: begin
              if (mul_acc < dnum) begin
                dnum <= '0;
              end else begin
                dnum <= mul_acc - dnum;
              end
              dden  <= 64'(jlen) * 64'(jlen);
              drem  <= '0;
              dquo  <= '0;
              dcnt  <= 8'd128;
              state <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          if (dcnt == 8'd0) begin
            if (!job_v) begin
              res_m[job_k] <= dquo;
            end else begin
              res_v[job_k] <= dquo;
            end
            state <= S_NEXT;
          end else begin
            dnum <= dnum << 1;
            if (rem_sh >= 65'(dden)) begin
              drem <= 64'(rem_sh - 65'(dden));
              dquo <= {dquo[62:0], 1'b1};
            end else begin
              drem <= rem_sh[63:0];
              dquo <= {dquo[62:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        S_NEXT: begin
          if (!job_v) begin
            job_v <= 1'b1;
            state <= S_SETUP;
          end else if (job_k == 2'd2) begin
            state <= S_OUT;
          end else begin
            job_v <= 1'b0;
            job_k <= job_k + 1'b1;
            state <= S_SETUP;
          end
        end
        S_OUT: begin
          done    <= 1'b1;
          count   <= '0;
          dropped <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_SETUP && jlen == '0) begin
        // empty suffix: skip division, reuse full window later
        state <= S_NEXT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      out_word.win_mean     <= (count == '0) ? 32'd0 : res_m[0][31:0];
      out_word.win_var      <= (count == '0) ? 64'd0 : res_v[0];
      out_word.half_mean    <= (count == '0) ? 32'd0 :
                               (h_len == '0) ? res_m[0][31:0] : res_m[1][31:0];
      out_word.half_var     <= (count == '0) ? 64'd0 :
                               (h_len == '0) ? res_v[0] : res_v[1];
      out_word.qtr_mean     <= (count == '0) ? 32'd0 :
                               (q_len == '0) ? res_m[0][31:0] : res_m[2][31:0];
      out_word.qtr_var      <= (count == '0) ? 64'd0 :
                               (q_len == '0) ? res_v[0] : res_v[2];
      out_word.min_distance <= (count == '0) ? 32'd0 : mn;
      out_word.overflow     <= dropped;
    end
  end

endmodule

@@ tb/sv/window_suffix_mean_variance_min_tb.sv @@
// ----------------------------------------------------------------------------
// window_suffix_mean_variance_min_tb
// Loads windows of distance samples, closes them and checks each statistics
// word against a predictor of the mean and variance of the whole window and
// of its newest half and quarter, the window minimum, and overflow from full stores.
// ----------------------------------------------------------------------------
module window_suffix_mean_variance_min_tb;
  import wsmv_pkg::*;

  localparam int WINDOW_MAX = 64;
  localparam int STALL_LIMIT = 5000;

  class window_stats_board;
    logic [31:0] samples [WINDOW_MAX];
    int unsigned n_samples;
    bit dropped;
    wsmv_out_t stats_q [$];
    bit failed;

    function new();
      n_samples = 0;
      dropped = 0;
      failed = 0;
    endfunction

    function void suffix(int unsigned len, output logic [31:0] mean,
                         output logic [63:0] var_q);
      logic [127:0] s1, s2, a, b, q;
      s1 = '0;
      s2 = '0;
      for (int unsigned i = n_samples - len; i < n_samples; i++) begin
        s1 += samples[i];
        s2 += 128'(samples[i]) * 128'(samples[i]);
      end
      q = s1 / len;
      mean = q[31:0];
      a = s2 * len;
      b = s1 * s1;
      q = (a < b) ? '0 : (a - b) / (len * len);
      var_q = q[63:0];
    endfunction

    function void note(wsmv_in_t w);
      wsmv_out_t e;
      if (w.has_sample) begin
        if (n_samples < WINDOW_MAX) begin
          samples[n_samples] = w.distance;
          n_samples++;
        end else begin
          dropped = 1;
        end
      end
      if (!w.last) return;
      e = '0;
      if (n_samples > 0) begin
        suffix(n_samples, e.win_mean, e.win_var);
        e.min_distance = samples[0];
        for (int unsigned i = 1; i < n_samples; i++)
          if (samples[i] < e.min_distance) e.min_distance = samples[i];
      end
      e.half_mean = e.win_mean;
      e.half_var = e.win_var;
      e.qtr_mean = e.win_mean;
      e.qtr_var = e.win_var;
      if (n_samples / 2 > 0) suffix(n_samples / 2, e.half_mean, e.half_var);
      if (n_samples / 4 > 0) suffix(n_samples / 4, e.qtr_mean, e.qtr_var);
      e.overflow = dropped;
      stats_q = {stats_q, e};
      n_samples = 0;
      dropped = 0;
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        failed = 1;
      end
    endfunction

    function void check(wsmv_out_t got);
      wsmv_out_t e;
      if (stats_q.size() == 0) begin
        $error("statistics word with none expected");
        failed = 1;
        return;
      end
      e = stats_q.pop_front();
      cmp("win_mean", e.win_mean, got.win_mean);
      cmp("win_var", e.win_var, got.win_var);
      cmp("half_mean", e.half_mean, got.half_mean);
      cmp("half_var", e.half_var, got.half_var);
      cmp("qtr_mean", e.qtr_mean, got.qtr_mean);
      cmp("qtr_var", e.qtr_var, got.qtr_var);
      cmp("min_distance", e.min_distance, got.min_distance);
      cmp("overflow", e.overflow, got.overflow);
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  wsmv_in_t in_word;
  wsmv_out_t out_word;
  window_stats_board board;
  int idle_pct;
  int n_sent;
  int stall_cnt;

  window_suffix_mean_variance_min #(.WINDOW_MAX(WINDOW_MAX)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .out_word(out_word)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) board.check(out_word);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("window_suffix_mean_variance_min_tb NOT OK");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // call at a falling edge; returns at a falling edge with start held high
  task automatic send(logic [31:0] d, bit has, bit lst);
    wsmv_in_t w;
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    w.distance = d;
    w.has_sample = has;
    w.last = lst;
    start <= 1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note(w);
    n_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_distance();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      3: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_window(int len);
    bit close_with_sample;
    close_with_sample = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len - close_with_sample; i++) begin
      if ($urandom_range(19) == 0) send($urandom, 0, 0);
      send(pick_distance(), 1, 0);
    end
    if (close_with_sample) send(pick_distance(), 1, 1);
    else send($urandom, 0, 1);
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (board.stats_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int len;
    clk = 0;
    rst = 1;
    start = 0;
    in_word = '0;
    idle_pct = 0;
    n_sent = 0;
    stall_cnt = 0;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // empty window, ignored word, lone sample closing, small windows
    send(32'hFFFF_FFFF, 0, 1);
    send(32'h1234_5678, 0, 0);
    send(32'hFFFF_FFFF, 1, 1);
    send(32'h0, 1, 1);
    send(32'hFFFF_FFFF, 1, 0);
    send(32'h0, 1, 0);
    send(32'h0, 0, 1);
    send(32'hFFFF_FFFF, 1, 0);
    send(32'hFFFF_FFFF, 1, 0);
    send(32'hFFFF_FFFF, 1, 1);
    send(32'h0001_0000, 1, 0);
    send(32'hAAAA_AAAA, 1, 0);
    send(32'h5555_5555, 1, 0);
    send(32'h8000_0000, 1, 0);
    send(32'h0, 1, 1);
    drain();

    while (n_sent < 1700) begin
      case ((n_sent / 300) % 4)
        0: idle_pct = 0;
        1: idle_pct = 55;
        2: idle_pct = 8;
        default: idle_pct = 55;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(0, 12);
        7, 8: len = $urandom_range(13, WINDOW_MAX);
        default: len = $urandom_range(WINDOW_MAX, WINDOW_MAX + 8);
      endcase
      send_window(len);
      if ($urandom_range(15) == 0) drain();
    end
    drain();
    repeat (600) @(posedge clk);
    if (!board.failed && board.stats_q.size() == 0) begin
      $display("window_suffix_mean_variance_min_tb OK");
    end else begin
      $display("window_suffix_mean_variance_min_tb NOT OK");
    end
    $finish;
  end

endmodule
